/* hdl/triple_echo_ranging_alarm_core_assert.svh */
// Assertion macros for the triple echo ranging alarm checker.
// Each macro expects a clock named clk and an active-low reset named rst_n in scope.
`ifndef TRIPLE_ECHO_RANGING_ALARM_CORE_ASSERT_SVH
`define TRIPLE_ECHO_RANGING_ALARM_CORE_ASSERT_SVH

// Same-cycle implication, checked only while out of reset
`define TERA_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tera same-cycle check failed");

// Next-cycle implication, checked only while out of reset
`define TERA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tera next-cycle check failed");

`endif

/* hdl/tera_pkg.sv */
// Shared types and constants for the triple echo ranging alarm core.
// Depends on nothing; used by every module of the block.
package tera_pkg;

    // Channel count and the lanes that actually carry an echo line
    localparam int CHANNELS  = 3;
    localparam int WIRED     = 3;
    localparam int WIRED_CNT = (CHANNELS < WIRED) ? CHANNELS : WIRED;

    localparam int TIMER_W = 16;
    localparam int DIST_W  = 10;
    localparam int MODE_W  = 2;

    // distance = floor(dur * 5 / 580) = floor(dur / 116); done as a multiply by
    // ceil(2^23 / 116) and a shift, exact for every 16-bit duration
    localparam int             RECIP_SHIFT = 23;
    localparam int             PROD_W      = 33;
    localparam logic [16:0]    RECIP_MUL   = 17'd72316;

    localparam logic [DIST_W-1:0] LIMIT_RESET = 10'd10;

    // Request commands
    localparam logic CMD_SAMPLE  = 1'b0;
    localparam logic CMD_REFRESH = 1'b1;

    // Alarm mode codes
    localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LEFT   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CENTER = 2'd2;
    localparam logic [MODE_W-1:0] MODE_RIGHT  = 2'd3;

    typedef struct packed {
        logic                 cmd;
        logic [WIRED-1:0]     echo_levels;
        logic [TIMER_W-1:0]   timer_value;
    } tera_req_t;

    typedef struct packed {
        logic [MODE_W-1:0]    alarm_mode;
        logic [DIST_W-1:0]    dist_left;
        logic [DIST_W-1:0]    dist_center;
        logic [DIST_W-1:0]    dist_right;
        logic [WIRED-1:0]     new_mask;
    } tera_rsp_t;

    // Per-lane status handed to the merge stage
    typedef struct packed {
        logic done;   // falling edge finished a measurement
        logic hit;    // new distance is at or below the limit
        logic far;    // stored distance exceeds the limit
    } tera_lane_t;

    // Alarm code of a lane
    function automatic logic [MODE_W-1:0] lane_code(input int idx);
        case (idx)
            0:       lane_code = MODE_LEFT;
            1:       lane_code = MODE_CENTER;
            2:       lane_code = MODE_RIGHT;
            default: lane_code = MODE_CLEAR;
        endcase
    endfunction

endpackage

/* hdl/tera_lane.sv */
// One echo channel: edge detection, start time capture and distance scaling.
// Depends on tera_pkg.
module tera_lane (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          level,
    input  logic [tera_pkg::TIMER_W-1:0]  timer_value,
    input  logic [tera_pkg::DIST_W-1:0]   limit,
    output logic [tera_pkg::DIST_W-1:0]   dist_next,
    output tera_pkg::tera_lane_t          stat
);
    import tera_pkg::*;

    logic                 prev_level_reg;
    logic [TIMER_W-1:0]   start_reg;
    logic [DIST_W-1:0]    dist_reg;
    logic [TIMER_W-1:0]   dur;
    logic [PROD_W-1:0]    prod;
    logic [DIST_W-1:0]    dist_new;
    logic                 rise;
    logic                 fall;

    assign rise = en && level && !prev_level_reg;
    assign fall = en && !level && prev_level_reg;

    // Scale the wrapped duration to centimeters
    assign dur      = timer_value - start_reg;
    assign prod     = PROD_W'(dur) * PROD_W'(RECIP_MUL);
    assign dist_new = prod[RECIP_SHIFT +: DIST_W];

    assign dist_next = fall ? dist_new : dist_reg;
    assign stat.done = fall;
    assign stat.hit  = fall && (dist_new <= limit);
    assign stat.far  = dist_reg > limit;

    // Track the line level and the stored distance
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_level_reg <= 1'b0;
            dist_reg       <= '0;
        end
        else if (en)
        begin
            prev_level_reg <= level;
            dist_reg       <= dist_next;
        end
    end

    // Latch the start time on a rising edge
    always_ff @(posedge clk)
    begin
        if (rise)
        begin
            start_reg <= timer_value;
        end
    end

endmodule

/* hdl/tera_merge.sv */
// Merge stage: combines lane status into the alarm mode and holds it.
// Depends on tera_pkg.
module tera_merge (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    acc,
    input  logic                                    cmd,
    input  tera_pkg::tera_lane_t [tera_pkg::WIRED_CNT-1:0] stat,
    output logic [tera_pkg::MODE_W-1:0]             mode_next
);
    import tera_pkg::*;

    logic [MODE_W-1:0]    mode_reg;
    logic                 all_far;

    // Resolve the next mode; later lanes override earlier ones
    always_comb
    begin
        all_far   = 1'b1;
        mode_next = mode_reg;
        for (int i = 0; i < WIRED_CNT; i++)
        begin
            all_far = all_far && stat[i].far;
        end
        if (acc)
        begin
            if (cmd == CMD_REFRESH)
            begin
                if (all_far)
                begin
                    mode_next = MODE_CLEAR;
                end
            end
            else
            begin
                for (int i = 0; i < WIRED_CNT; i++)
                begin
                    if (stat[i].hit)
                    begin
                        mode_next = lane_code(i);
                    end
                end
            end
        end
    end

    // Hold the mode
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_CLEAR;
        end
        else
        begin
            mode_reg <= mode_next;
        end
    end

endmodule

/* hdl/triple_echo_ranging_alarm_core.sv */
// Triple echo ranging alarm: top level with the lanes, merge stage and output register.
// Depends on tera_pkg, tera_lane and tera_merge.
//
// Each request is one sample of the three echo lines plus the timer, or a refresh
// command, and gives exactly one response in the cycle after it is taken. A request can be
// taken every cycle: each channel lane does its subtraction and constant multiply in
// the accepting cycle, so the throughput is one request per clock, limited only by the
// response register being drained. The near limit is written through cfg_valid/cfg_data
// and resets to 10; cfg_ready is always high.
module triple_echo_ranging_alarm_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_ready,
    input  tera_pkg::tera_req_t           req,
    output logic                          rsp_valid,
    input  logic                          rsp_ready,
    output tera_pkg::tera_rsp_t           rsp,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [tera_pkg::DIST_W-1:0]   cfg_data
);
    import tera_pkg::*;

    logic                           req_acc;
    logic                           sample_en;
    logic [DIST_W-1:0]              limit_reg;
    logic                           rsp_valid_reg;
    tera_rsp_t                      rsp_reg;
    tera_rsp_t                      rsp_next;
    tera_lane_t [WIRED_CNT-1:0]     stat;
    logic [DIST_W-1:0]              dist_all [WIRED];
    logic [WIRED-1:0]               done_mask;
    logic [MODE_W-1:0]              mode_next;

    assign req_ready = !rsp_valid_reg || rsp_ready;
    assign req_acc   = req_valid && req_ready;
    assign sample_en = req_acc && (req.cmd == CMD_SAMPLE);
    assign cfg_ready = 1'b1;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Lanes for wired channels; absent channels read as zero
    for (genvar g = 0; g < WIRED; g++)
    begin : g_lane
        if (g < WIRED_CNT)
        begin : g_on
            tera_lane u_lane (
                .clk         (clk),
                .rst_n       (rst_n),
                .en          (sample_en),
                .level       (req.echo_levels[g]),
                .timer_value (req.timer_value),
                .limit       (limit_reg),
                .dist_next   (dist_all[g]),
                .stat        (stat[g])
            );
            assign done_mask[g] = stat[g].done;
        end
        else
        begin : g_off
            assign dist_all[g]  = '0;
            assign done_mask[g] = 1'b0;
        end
    end

    tera_merge u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .acc       (req_acc),
        .cmd       (req.cmd),
        .stat      (stat),
        .mode_next (mode_next)
    );

    // Assemble the response
    always_comb
    begin
        rsp_next.alarm_mode  = mode_next;
        rsp_next.dist_left   = dist_all[0];
        rsp_next.dist_center = dist_all[1];
        rsp_next.dist_right  = dist_all[2];
        rsp_next.new_mask    = done_mask;
    end

    // Hold the limit and the response valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg     <= LIMIT_RESET;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                limit_reg <= cfg_data;
            end
            if (req_acc)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Advance the response payload on each taken request
    always_ff @(posedge clk)
    begin
        if (req_acc)
        begin
            rsp_reg <= rsp_next;
        end
    end

endmodule

/* hdl/tera_checker.sv */
// Port-level checks for the triple echo ranging alarm core, bound to the top level.
// Depends on tera_pkg and triple_echo_ranging_alarm_core_assert.svh.
`include "triple_echo_ranging_alarm_core_assert.svh"

module tera_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    input  logic                          req_ready,
    input  tera_pkg::tera_req_t           req,
    input  logic                          rsp_valid,
    input  logic                          rsp_ready,
    input  tera_pkg::tera_rsp_t           rsp,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [tera_pkg::DIST_W-1:0]   cfg_data
);
    import tera_pkg::*;

    logic req_acc;
    logic cfg_seen;
    logic refresh_acc;

    assign req_acc     = req_valid && req_ready;
    assign cfg_seen    = cfg_valid && cfg_ready && (cfg_data == cfg_data);
    assign refresh_acc = req_acc && (req.cmd == CMD_REFRESH) && !cfg_seen;

    // A taken request always shows a response in the next cycle
    `TERA_ASSERT_NEXT(a_rsp_follows, req_acc, rsp_valid)

    // A refresh taken without a limit write in the same cycle never reports a finished measurement
    `TERA_ASSERT_NEXT(a_refresh_no_new, refresh_acc, rsp.new_mask == '0)

    // A stalled response blocks new requests
    `TERA_ASSERT_NOW(a_stall_blocks, rsp_valid && !rsp_ready, !req_ready)

    // A stalled response holds its payload
    `TERA_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp))

endmodule

bind triple_echo_ranging_alarm_core tera_checker u_tera_checker (.*);

/* test/triple_echo_ranging_alarm_core_tb.sv */
// Self-checking testbench for triple_echo_ranging_alarm_core: echo samples and refreshes
// against a cycle-free predictor of the stored distances and alarm mode.
// Depends on tera_pkg and the RTL of the core.
`timescale 1ns / 100ps

module triple_echo_ranging_alarm_core_tb;

    import tera_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int IDLE_PCT       = 12;
    localparam int PHASE_ITEMS    = 140;

    // Predicts one readout per request and checks the readouts in order
    class echo_range_tracker;
        logic [DIST_W-1:0]  near_limit;
        logic [WIRED-1:0]   prev_levels;
        logic [TIMER_W-1:0] start_time [WIRED];
        logic [DIST_W-1:0]  dist_cm [WIRED];
        logic [MODE_W-1:0]  mode;
        tera_rsp_t          pending_readouts [$];
        int                 errors;
        int                 refreshes;
        int                 measurements;
        int                 alarm_hits;

        function new();
            near_limit   = LIMIT_RESET;
            prev_levels  = '0;
            mode         = MODE_CLEAR;
            errors       = 0;
            refreshes    = 0;
            measurements = 0;
            alarm_hits   = 0;
            foreach (dist_cm[i])
            begin
                dist_cm[i]    = '0;
                start_time[i] = '0;
            end
        endfunction

        function bit all_beyond_limit();
            for (int i = 0; i < WIRED_CNT; i++)
            begin
                if (dist_cm[i] <= near_limit)
                    return 1'b0;
            end
            return 1'b1;
        endfunction

        // Advance the channel state for an accepted request and queue its readout
        function void note_request(tera_req_t r);
            tera_rsp_t          want;
            logic [WIRED-1:0]   changed;
            logic [TIMER_W-1:0] dur;
            logic [DIST_W-1:0]  d;
            logic [WIRED-1:0]   done;
            done = '0;
            if (r.cmd == CMD_REFRESH)
            begin
                refreshes++;
                if (all_beyond_limit())
                    mode = MODE_CLEAR;
            end
            else
            begin
                changed = r.echo_levels ^ prev_levels;
                for (int i = 0; i < WIRED_CNT; i++)
                begin
                    if (changed[i])
                    begin
                        if (r.echo_levels[i])
                            start_time[i] = r.timer_value;
                        else
                        begin
                            dur        = r.timer_value - start_time[i];
                            d          = DIST_W'((32'(dur) * 32'd5) / 32'd580);
                            dist_cm[i] = d;
                            done[i]    = 1'b1;
                            measurements++;
                            // left, center, right in turn: the last near channel wins
                            if (d <= near_limit)
                            begin
                                alarm_hits++;
                                case (i)
                                    0:       mode = MODE_LEFT;
                                    1:       mode = MODE_CENTER;
                                    2:       mode = MODE_RIGHT;
                                    default: mode = mode;
                                endcase
                            end
                        end
                    end
                end
                prev_levels = r.echo_levels;
            end
            want.alarm_mode  = mode;
            want.dist_left   = dist_cm[0];
            want.dist_center = dist_cm[1];
            want.dist_right  = dist_cm[2];
            want.new_mask    = done;
            pending_readouts.push_back(want);
        endfunction

        function void compare_field(string name, logic [15:0] want, logic [15:0] got);
            if (got !== want)
            begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            end
        endfunction

        // Check one accepted readout against the oldest prediction
        function void check_readout(tera_rsp_t got);
            tera_rsp_t want;
            if (pending_readouts.size() == 0)
            begin
                errors++;
                $display("%0t: readout with none expected, actual %p", $time, got);
                return;
            end
            want = pending_readouts.pop_front();
            compare_field("alarm_mode", 16'(want.alarm_mode), 16'(got.alarm_mode));
            compare_field("dist_left", 16'(want.dist_left), 16'(got.dist_left));
            compare_field("dist_center", 16'(want.dist_center), 16'(got.dist_center));
            compare_field("dist_right", 16'(want.dist_right), 16'(got.dist_right));
            compare_field("new_mask", 16'(want.new_mask), 16'(got.new_mask));
        endfunction
    endclass

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                req_valid = 1'b0;
    logic                req_ready;
    tera_req_t           req = '0;
    logic                rsp_valid;
    logic                rsp_ready = 1'b0;
    tera_rsp_t           rsp;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [DIST_W-1:0]   cfg_data = '0;

    echo_range_tracker   tracker = new();
    bit                  steady = 1'b0;
    int                  idle_cycles = 0;
    int                  limit_writes = 0;
    logic [TIMER_W-1:0]  tick = '0;
    logic [WIRED-1:0]    levels = '0;

    triple_echo_ranging_alarm_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Stall the readout side at random, except during the steady stretch
    always @(negedge clk)
    begin
        rsp_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end

    // Check readouts and guard against a hung handshake
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_valid && rsp_ready)
                tracker.check_readout(rsp);
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else if (idle_cycles + 1 >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("Simulation FAILED");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // Present one request, with an optional gap first; enter and leave at a falling edge
    task automatic send_request(input tera_req_t r);
        int gap;
        gap = 0;
        if (!steady && $urandom_range(99) < IDLE_PCT)
            gap = $urandom_range(4, 1);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_valid <= 1'b1;
        req       <= r;
        do
            @(posedge clk);
        while (!req_ready);
        tracker.note_request(r);
        @(negedge clk);
    endtask

    task automatic send_fields(input logic c, input logic [WIRED-1:0] lv,
                               input logic [TIMER_W-1:0] t);
        tera_req_t r;
        r.cmd         = c;
        r.echo_levels = lv;
        r.timer_value = t;
        if (c == CMD_SAMPLE)
            levels = lv;
        send_request(r);
    endtask

    // Drain all readouts, let the core settle, then write the near limit
    task automatic write_limit(input logic [DIST_W-1:0] value);
        req_valid <= 1'b0;
        while (tracker.pending_readouts.size() != 0)
            @(negedge clk);
        repeat (2) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        tracker.near_limit = value;
        limit_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Mostly well-formed echo pulses on an advancing timer, plus refreshes and noise
    task automatic send_random_phase(input int count);
        int roll;
        int step;
        for (int n = 0; n < count; n++)
        begin
            roll = $urandom_range(99);
            if (roll < 10)
                send_fields(CMD_REFRESH, WIRED'($urandom_range(7)), TIMER_W'($urandom));
            else if (roll < 20)
            begin
                tick = TIMER_W'($urandom);
                send_fields(CMD_SAMPLE, WIRED'($urandom_range(7)), tick);
            end
            else
            begin
                step = ($urandom_range(9) == 0) ? $urandom_range(65535) : $urandom_range(1500);
                tick = tick + TIMER_W'(step);
                for (int b = 0; b < WIRED; b++)
                begin
                    if ($urandom_range(3) == 0)
                        levels[b] = !levels[b];
                end
                send_fields(CMD_SAMPLE, levels, tick);
            end
        end
    endtask

    initial
    begin
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: refresh from reset, all edges at once, wrap, extremes, ignored fields
        send_fields(CMD_REFRESH, 3'd0, 16'h0000);
        send_fields(CMD_SAMPLE, 3'd7, 16'h0000);
        send_fields(CMD_SAMPLE, 3'd7, 16'd500);
        send_fields(CMD_SAMPLE, 3'd0, 16'd580);
        send_fields(CMD_REFRESH, 3'd0, 16'h0000);
        send_fields(CMD_SAMPLE, 3'd1, 16'hFFFF);
        send_fields(CMD_SAMPLE, 3'd0, 16'h0400);
        send_fields(CMD_SAMPLE, 3'd2, 16'd100);
        send_fields(CMD_SAMPLE, 3'd0, 16'd1376);
        send_fields(CMD_SAMPLE, 3'd4, 16'h0000);
        send_fields(CMD_SAMPLE, 3'd0, 16'hFFFF);
        send_fields(CMD_SAMPLE, 3'd1, 16'h0000);
        send_fields(CMD_SAMPLE, 3'd0, 16'hFFFF);
        send_fields(CMD_REFRESH, 3'd7, 16'hFFFF);
        send_fields(CMD_SAMPLE, 3'd3, 16'd1000);
        send_fields(CMD_REFRESH, 3'd0, 16'h5555);
        send_fields(CMD_SAMPLE, 3'd0, 16'd2160);
        send_fields(CMD_SAMPLE, 3'd6, 16'hAAAA);
        send_fields(CMD_SAMPLE, 3'd7, 16'hAAAA);
        send_fields(CMD_SAMPLE, 3'd1, 16'hAB00);
        send_fields(CMD_SAMPLE, 3'd0, 16'h5555);

        // Random phases under different near limits, extremes included
        send_random_phase(PHASE_ITEMS);
        write_limit(10'd0);
        send_random_phase(PHASE_ITEMS);
        write_limit(10'd564);
        steady = 1'b1;
        send_random_phase(PHASE_ITEMS);
        steady = 1'b0;
        write_limit(10'd511);
        send_random_phase(PHASE_ITEMS);
        write_limit(DIST_W'($urandom_range(564)));
        send_random_phase(PHASE_ITEMS);
        write_limit(10'd40);
        send_random_phase(PHASE_ITEMS - 15);

        // Drain and settle
        req_valid <= 1'b0;
        while (tracker.pending_readouts.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);

        if (tracker.pending_readouts.size() != 0)
        begin
            tracker.errors++;
            $display("%0t: %0d readouts never arrived", $time, tracker.pending_readouts.size());
        end
        $display("Covered %0d refreshes, %0d finished echo measurements, %0d near hits",
                 tracker.refreshes, tracker.measurements, tracker.alarm_hits);
        $display("across %0d near-limit writes, %0d mismatches", limit_writes, tracker.errors);
        if (tracker.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
